// ===== src/aapr_pkg.sv =====
// ----------------------------------------------------------------------------
// aapr_pkg: shared types and constants of the axis-angle point rotator
// Fixed-point constants (Q2.30), register codes, configuration and matrix
// types, and the rounding and saturation helpers used by several modules.
// ----------------------------------------------------------------------------
package aapr_pkg;

    localparam int Q_BITS = 30;
    localparam logic [31:0] ONE_Q = 32'h4000_0000;
    localparam logic [31:0] PI_Q = 32'd3373259426;
    localparam logic [31:0] HALF_PI_Q = 32'd1686629713;
    localparam int DIV_W = 62;
    localparam int ANGLE_W = 19;

    typedef enum logic [2:0] {
        REG_PIVOT_X = 3'd0,
        REG_PIVOT_Y = 3'd1,
        REG_PIVOT_Z = 3'd2,
        REG_AXIS_X  = 3'd3,
        REG_AXIS_Y  = 3'd4,
        REG_AXIS_Z  = 3'd5,
        REG_ANGLE   = 3'd6
    } t_reg_idx;

    typedef struct packed {
        logic [2:0][31:0]     pivot;
        logic [2:0][31:0]     axis;
        logic [ANGLE_W-1:0]   angle;
    } t_cfg;

    // row-major 3x3, entries signed Q2.30 clamped to +-1.0
    typedef logic [8:0][31:0] t_mtx;

    function automatic logic [31:0] mag32(input logic [31:0] v);
        return v[31] ? 32'(-v) : v;
    endfunction

    // round(p / 2^30) to nearest, ties away from zero, then apply the sign
    function automatic logic signed [34:0] rnd_q30(input logic [63:0] p, input logic neg);
        logic [64:0] s;
        logic [34:0] m;
        s = {1'b0, p} + 65'(ONE_Q >> 1);
        m = s[64:30];
        return neg ? -$signed(m) : $signed(m);
    endfunction

    function automatic logic [31:0] sat32(input logic signed [35:0] v);
        if (v > 36'sd2147483647) begin
            return 32'h7FFF_FFFF;
        end else if (v < -36'sd2147483648) begin
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

endpackage

// ===== src/aapr_in_if.sv =====
// ----------------------------------------------------------------------------
// aapr_in_if: point request channel
// Valid/ready channel that carries one point and its normal.
// ----------------------------------------------------------------------------
interface aapr_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic signed [31:0] normal_x;
    logic signed [31:0] normal_y;
    logic signed [31:0] normal_z;

    modport source (
        output valid, point_x, point_y, point_z, normal_x, normal_y, normal_z,
        input  ready
    );
    modport sink (
        input  valid, point_x, point_y, point_z, normal_x, normal_y, normal_z,
        output ready
    );
endinterface

// ===== src/aapr_out_if.sv =====
// ----------------------------------------------------------------------------
// aapr_out_if: rotated point channel
// Valid/ready channel that carries one rotated point and its rotated normal.
// ----------------------------------------------------------------------------
interface aapr_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] rotated_x;
    logic signed [31:0] rotated_y;
    logic signed [31:0] rotated_z;
    logic signed [31:0] rotated_normal_x;
    logic signed [31:0] rotated_normal_y;
    logic signed [31:0] rotated_normal_z;

    modport source (
        output valid, rotated_x, rotated_y, rotated_z,
               rotated_normal_x, rotated_normal_y, rotated_normal_z,
        input  ready
    );
    modport sink (
        input  valid, rotated_x, rotated_y, rotated_z,
               rotated_normal_x, rotated_normal_y, rotated_normal_z,
        output ready
    );
endinterface

// ===== src/axis_angle_point_rotator.sv =====
// ----------------------------------------------------------------------------
// axis_angle_point_rotator: rotate points and normals about an axis
// Rodrigues rotation about an axis through a pivot, signed fixed point.
// ----------------------------------------------------------------------------
// Usage:
//   i_pnt carries requests of one point and its normal, o_rot carries the
//   rotated point and normal, both valid/ready. Pivot, axis and angle are set
//   through the write port (i_cfg_we, i_cfg_idx, i_cfg_data).
//   Throughput: one request per cycle unless o_rot stalls or the matrix is
//   being rebuilt. An accepted request passes the registered stages offset,
//   products, sums and saturation to o_rot. The rotation matrix depends only
//   on the registers. After reset and after every register write the matrix
//   builder runs and holds i_pnt.ready low. Near a zero angle it loads the
//   identity; otherwise it runs the Taylor terms, the axis scaling, the
//   one-bit-per-cycle square root and the three axis divisions.
//   Reset clears the pipeline valid bits and loads pivot (0,0,0), axis
//   (0,0,1.0) and angle 0. When o_rot stalls, each stage holds its request;
//   empty stages keep filling, so up to four requests are held in flight.
// ----------------------------------------------------------------------------
module axis_angle_point_rotator import aapr_pkg::*; #(
    parameter int FRACTION_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    aapr_in_if.sink     i_pnt,
    aapr_out_if.source  o_rot
);

    t_cfg r_cfg;
    logic mtx_busy;
    t_mtx mtx;

    // register file; any write restarts the matrix build
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pivot <= '0;
            r_cfg.axis  <= {32'h0001_0000, 32'd0, 32'd0};
            r_cfg.angle <= '0;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_PIVOT_X: r_cfg.pivot[0] <= i_cfg_data;
                REG_PIVOT_Y: r_cfg.pivot[1] <= i_cfg_data;
                REG_PIVOT_Z: r_cfg.pivot[2] <= i_cfg_data;
                REG_AXIS_X:  r_cfg.axis[0]  <= i_cfg_data;
                REG_AXIS_Y:  r_cfg.axis[1]  <= i_cfg_data;
                REG_AXIS_Z:  r_cfg.axis[2]  <= i_cfg_data;
                REG_ANGLE:   r_cfg.angle    <= i_cfg_data[ANGLE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // sin/cos, unit axis and matrix, rebuilt after each write
    aapr_mtx #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_mtx (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_restart (i_cfg_we),
        .i_cfg     (r_cfg),
        .o_busy    (mtx_busy),
        .o_mtx     (mtx)
    );

    // streaming transform; hold off requests while the matrix is rebuilt
    aapr_pipe u_pipe (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_hold  (mtx_busy),
        .i_mtx   (mtx),
        .i_pivot (r_cfg.pivot),
        .i_pnt   (i_pnt),
        .o_rot   (o_rot)
    );

endmodule

// ===== src/aapr_div.sv =====
// ----------------------------------------------------------------------------
// aapr_div: iterative unsigned divider
// Restoring divider, one quotient bit per cycle; done pulses for one cycle.
// ----------------------------------------------------------------------------
module aapr_div import aapr_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DIV_W-1:0] i_dividend,
    input  logic [31:0]      i_divisor,
    output logic             o_done,
    output logic [DIV_W-1:0] o_quot
);

    localparam int CW = $clog2(DIV_W);

    logic             r_busy;
    logic             r_done;
    logic [CW-1:0]    r_cnt;
    logic [DIV_W-1:0] r_dvd;
    logic [DIV_W-1:0] r_q;
    logic [31:0]      r_rem;
    logic [31:0]      r_dvs;
    logic [32:0]      trial;
    logic [32:0]      diff;
    logic             take;

    always_comb begin
        trial = {r_rem, r_dvd[DIV_W-1]};
        diff  = trial - {1'b0, r_dvs};
        take  = trial >= {1'b0, r_dvs};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= CW'(DIV_W - 1);
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end else begin
                r_cnt <= r_cnt - 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_dvs <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_rem <= take ? diff[31:0] : trial[31:0];
            r_q   <= {r_q[DIV_W-2:0], take};
            r_dvd <= r_dvd << 1;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

// ===== src/aapr_mtx.sv =====
// ----------------------------------------------------------------------------
// aapr_mtx: rotation matrix builder
// Sequencer with one shared 32x32 multiplier and a small one for the Taylor divisor: Taylor sin/cos, axis scaling,
// integer square root, axis division and the Rodrigues matrix terms.
// ----------------------------------------------------------------------------
module aapr_mtx import aapr_pkg::*; #(
    parameter int FRACTION_BITS = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_restart,
    input  t_cfg i_cfg,
    output logic o_busy,
    output t_mtx o_mtx
);

    localparam int XW = ANGLE_W + Q_BITS - FRACTION_BITS;
    localparam int SMALL_MAX = ((1 << FRACTION_BITS) - 1) / 1000000;
    localparam logic [63:0] RECIP_NUM = 64'h1_0000_0000;

    typedef enum logic [4:0] {
        ST_IDLE, ST_START, ST_TM1, ST_TM2, ST_TM3, ST_TDIV, ST_SC,
        ST_AX0, ST_AXSH, ST_SQ0, ST_SQ1, ST_SQ2, ST_SQ3, ST_ISQ,
        ST_UD0, ST_UD1, ST_MA, ST_MB, ST_MC, ST_MD, ST_CS0, ST_CS1, ST_FIN
    } t_state;

    t_state             r_st;
    logic               r_busy;
    logic [30:0]        r_x;
    logic               r_flip;
    logic [31:0]        r_t;
    logic signed [35:0] r_ss;
    logic signed [35:0] r_cc;
    logic [4:0]         r_n;
    logic               r_cos;
    logic signed [31:0] r_s;
    logic signed [31:0] r_c;
    logic [31:0]        r_w [3];
    logic [63:0]        r_sum;
    logic [63:0]        r_rem;
    logic [63:0]        r_res;
    logic [4:0]         r_k;
    logic [31:0]        r_len;
    logic signed [31:0] r_u [3];
    logic [1:0]         r_i;
    logic [1:0]         r_j;
    logic signed [34:0] r_q;
    logic signed [34:0] r_cs [3];
    logic signed [34:0] r_tr [9];
    logic [63:0]        r_prod;
    logic               r_pneg;
    t_mtx               r_mtx;

    logic [ANGLE_W-1:0] am;
    logic               near_zero;
    logic [XW-1:0]      xs;
    logic [31:0]        xc;
    logic [31:0]        xf;
    logic               flip;
    logic [31:0]        mul_a;
    logic [31:0]        mul_b;
    logic               mul_neg;
    logic [63:0]        prod;
    logic signed [34:0] rq;
    logic [63:0]        bit64;
    logic [63:0]        tst;
    logic               ge;
    logic [63:0]        n_res;
    logic [9:0]         nprod;
    logic [31:0]        vers;
    logic [3:0]         idx;
    logic [31:0]        w_any;
    logic [31:0]        recip;
    logic [31:0]        q0;
    logic [41:0]        qk;
    logic [41:0]        qrem;
    logic [31:0]        tq;
    logic               div_start;
    logic [DIV_W-1:0]   div_dvd;
    logic [31:0]        div_dvs;
    logic               div_done;
    logic [DIV_W-1:0]   div_q;
    logic signed [35:0] term;
    logic [31:0]        ssc;
    logic [31:0]        ccc;
    logic signed [34:0] adj [9];
    t_mtx               ident;
    t_mtx               fin;

    function automatic logic [31:0] clamp_one(input logic signed [34:0] v);
        if (v > 35'sd1073741824) begin
            return ONE_Q;
        end else if (v < -35'sd1073741824) begin
            return 32'hC000_0000;
        end
        return v[31:0];
    endfunction

    // angle to Q30 magnitude, saturate at pi, fold into the first quadrant
    always_comb begin
        am        = i_cfg.angle[ANGLE_W-1] ? ANGLE_W'(-i_cfg.angle) : i_cfg.angle;
        near_zero = am <= ANGLE_W'(SMALL_MAX);
        xs        = XW'(am) << (Q_BITS - FRACTION_BITS);
        xc        = (64'(xs) > 64'(PI_Q)) ? PI_Q : 32'(xs);
        flip      = xc > HALF_PI_Q;
        xf        = flip ? (PI_Q - xc) : xc;
    end

    // floor(2^32 / n(n-1)) for the Taylor term divisors
    always_comb begin
        case (r_n)
            5'd2:    recip = 32'(RECIP_NUM / 64'd2);
            5'd3:    recip = 32'(RECIP_NUM / 64'd6);
            5'd4:    recip = 32'(RECIP_NUM / 64'd12);
            5'd5:    recip = 32'(RECIP_NUM / 64'd20);
            5'd6:    recip = 32'(RECIP_NUM / 64'd30);
            5'd7:    recip = 32'(RECIP_NUM / 64'd42);
            5'd8:    recip = 32'(RECIP_NUM / 64'd56);
            5'd9:    recip = 32'(RECIP_NUM / 64'd72);
            5'd10:   recip = 32'(RECIP_NUM / 64'd90);
            5'd11:   recip = 32'(RECIP_NUM / 64'd110);
            5'd12:   recip = 32'(RECIP_NUM / 64'd132);
            5'd13:   recip = 32'(RECIP_NUM / 64'd156);
            5'd14:   recip = 32'(RECIP_NUM / 64'd182);
            5'd15:   recip = 32'(RECIP_NUM / 64'd210);
            5'd16:   recip = 32'(RECIP_NUM / 64'd240);
            5'd17:   recip = 32'(RECIP_NUM / 64'd272);
            default: recip = '0;
        endcase
    end

    always_comb begin
        mul_a   = '0;
        mul_b   = '0;
        mul_neg = 1'b0;
        case (r_st)
            ST_TM1: begin
                mul_a = r_t;
                mul_b = {1'b0, r_x};
            end
            ST_TM2: begin
                mul_a = r_prod[61:30];
                mul_b = {1'b0, r_x};
            end
            ST_TM3: begin
                mul_a = r_prod[61:30];
                mul_b = recip;
            end
            ST_SQ0: begin
                mul_a = r_w[0];
                mul_b = r_w[0];
            end
            ST_SQ1: begin
                mul_a = r_w[1];
                mul_b = r_w[1];
            end
            ST_SQ2: begin
                mul_a = r_w[2];
                mul_b = r_w[2];
            end
            ST_MA: begin
                mul_a   = mag32(r_u[r_i]);
                mul_b   = mag32(r_u[r_j]);
                mul_neg = r_u[r_i][31] ^ r_u[r_j][31];
            end
            ST_MC: begin
                mul_a   = r_q[34] ? 32'(-r_q) : 32'(r_q);
                mul_b   = vers;
                mul_neg = r_q[34];
            end
            ST_CS0: begin
                mul_a   = mag32(r_u[r_i]);
                mul_b   = mag32(r_s);
                mul_neg = r_u[r_i][31] ^ r_s[31];
            end
            default: begin
            end
        endcase
        prod = 64'(mul_a) * 64'(mul_b);
    end

    always_comb begin
        rq    = rnd_q30(r_prod, r_pneg);
        bit64 = 64'(1) << {r_k, 1'b0};
        tst   = r_res + bit64;
        ge    = r_rem >= tst;
        n_res = ge ? ((r_res >> 1) + bit64) : (r_res >> 1);
        nprod = 10'(r_n) * 10'(r_n - 5'd1);
        vers  = ONE_Q - r_c;
        idx   = 4'(r_i) * 4'd3 + 4'(r_j);
        w_any = r_w[0] | r_w[1] | r_w[2];
        // reciprocal estimate is low by at most one; fix it with the remainder
        q0    = r_prod[63:32];
        qk    = 42'(q0) * 42'(nprod);
        qrem  = 42'(r_t) - qk;
        tq    = (qrem >= 42'(nprod)) ? (q0 + 32'd1) : q0;
        term  = 36'(tq);
        if (r_ss < 0) begin
            ssc = '0;
        end else if (r_ss > 36'(ONE_Q)) begin
            ssc = ONE_Q;
        end else begin
            ssc = r_ss[31:0];
        end
        if (r_cc < 0) begin
            ccc = '0;
        end else if (r_cc > 36'(ONE_Q)) begin
            ccc = ONE_Q;
        end else begin
            ccc = r_cc[31:0];
        end
    end

    // skew-symmetric sin terms on top of the symmetric part, then clamp
    always_comb begin
        for (int e = 0; e < 9; e++) begin
            adj[e] = r_tr[e];
        end
        adj[1] = r_tr[1] - r_cs[2];
        adj[3] = r_tr[3] + r_cs[2];
        adj[2] = r_tr[2] + r_cs[1];
        adj[6] = r_tr[6] - r_cs[1];
        adj[5] = r_tr[5] - r_cs[0];
        adj[7] = r_tr[7] + r_cs[0];
        for (int e = 0; e < 9; e++) begin
            fin[e]   = clamp_one(adj[e]);
            ident[e] = (e % 4 == 0) ? ONE_Q : 32'd0;
        end
    end

    always_comb begin
        div_start = (r_st == ST_UD0);
        div_dvd   = {r_w[r_i], 30'd0};
        div_dvs   = r_len;
    end

    aapr_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dvd),
        .i_divisor  (div_dvs),
        .o_done     (div_done),
        .o_quot     (div_q)
    );

    always_ff @(posedge i_clk) begin
        r_prod <= prod;
        r_pneg <= mul_neg;
        if (!i_rst_n) begin
            r_st   <= ST_START;
            r_busy <= 1'b1;
        end else if (i_restart) begin
            r_st   <= ST_START;
            r_busy <= 1'b1;
        end else begin
            unique case (r_st)
                ST_IDLE: begin
                end
                ST_START: begin
                    if (near_zero) begin
                        r_mtx  <= ident;
                        r_busy <= 1'b0;
                        r_st   <= ST_IDLE;
                    end else begin
                        r_x    <= xf[30:0];
                        r_flip <= flip;
                        r_t    <= xf;
                        r_ss   <= 36'(xf);
                        r_n    <= 5'd3;
                        r_cos  <= 1'b0;
                        r_st   <= ST_TM1;
                    end
                end
                ST_TM1: r_st <= ST_TM2;
                ST_TM2: r_st <= ST_TM3;
                ST_TM3: begin
                    r_t  <= r_prod[61:30];
                    r_st <= ST_TDIV;
                end
                ST_TDIV: begin
                    r_t <= tq;
                    if (!r_cos) begin
                        r_ss <= r_n[1] ? (r_ss - term) : (r_ss + term);
                        if (r_n == 5'd17) begin
                            r_cos <= 1'b1;
                            r_n   <= 5'd2;
                            r_t   <= ONE_Q;
                            r_cc  <= 36'(ONE_Q);
                        end else begin
                            r_n <= r_n + 5'd2;
                        end
                        r_st <= ST_TM1;
                    end else begin
                        r_cc <= r_n[1] ? (r_cc - term) : (r_cc + term);
                        if (r_n == 5'd16) begin
                            r_st <= ST_SC;
                        end else begin
                            r_n  <= r_n + 5'd2;
                            r_st <= ST_TM1;
                        end
                    end
                end
                ST_SC: begin
                    r_s  <= i_cfg.angle[ANGLE_W-1] ? $signed(32'(-ssc)) : $signed(ssc);
                    r_c  <= r_flip ? $signed(32'(-ccc)) : $signed(ccc);
                    r_st <= ST_AX0;
                end
                ST_AX0: begin
                    for (int i = 0; i < 3; i++) begin
                        r_w[i] <= mag32(i_cfg.axis[i]);
                    end
                    if (i_cfg.axis == '0) begin
                        for (int i = 0; i < 3; i++) begin
                            r_u[i] <= '0;
                        end
                        r_i  <= '0;
                        r_j  <= '0;
                        r_st <= ST_MA;
                    end else begin
                        r_st <= ST_AXSH;
                    end
                end
                ST_AXSH: begin
                    if (w_any[31:30] == 2'b00) begin
                        for (int i = 0; i < 3; i++) begin
                            r_w[i] <= r_w[i] << 1;
                        end
                    end else begin
                        r_st <= ST_SQ0;
                    end
                end
                ST_SQ0: r_st <= ST_SQ1;
                ST_SQ1: begin
                    r_sum <= r_prod;
                    r_st  <= ST_SQ2;
                end
                ST_SQ2: begin
                    r_sum <= r_sum + r_prod;
                    r_st  <= ST_SQ3;
                end
                ST_SQ3: begin
                    r_rem <= r_sum + r_prod;
                    r_res <= '0;
                    r_k   <= 5'd31;
                    r_st  <= ST_ISQ;
                end
                ST_ISQ: begin
                    if (ge) begin
                        r_rem <= r_rem - tst;
                    end
                    r_res <= n_res;
                    if (r_k == '0) begin
                        r_len <= n_res[31:0];
                        r_i   <= '0;
                        r_st  <= ST_UD0;
                    end else begin
                        r_k <= r_k - 5'd1;
                    end
                end
                ST_UD0: r_st <= ST_UD1;
                ST_UD1: begin
                    if (div_done) begin
                        r_u[r_i] <= i_cfg.axis[r_i][31] ? $signed(32'(-div_q[31:0]))
                                                        : $signed(div_q[31:0]);
                        if (r_i == 2'd2) begin
                            r_i  <= '0;
                            r_j  <= '0;
                            r_st <= ST_MA;
                        end else begin
                            r_i  <= r_i + 2'd1;
                            r_st <= ST_UD0;
                        end
                    end
                end
                ST_MA: r_st <= ST_MB;
                ST_MB: begin
                    r_q  <= rq;
                    r_st <= ST_MC;
                end
                ST_MC: r_st <= ST_MD;
                ST_MD: begin
                    r_tr[idx] <= rq + ((r_i == r_j) ? 35'(r_c) : 35'sd0);
                    if (r_j == 2'd2) begin
                        r_j <= '0;
                        if (r_i == 2'd2) begin
                            r_i  <= '0;
                            r_st <= ST_CS0;
                        end else begin
                            r_i  <= r_i + 2'd1;
                            r_st <= ST_MA;
                        end
                    end else begin
                        r_j  <= r_j + 2'd1;
                        r_st <= ST_MA;
                    end
                end
                ST_CS0: r_st <= ST_CS1;
                ST_CS1: begin
                    r_cs[r_i] <= rq;
                    if (r_i == 2'd2) begin
                        r_st <= ST_FIN;
                    end else begin
                        r_i  <= r_i + 2'd1;
                        r_st <= ST_CS0;
                    end
                end
                ST_FIN: begin
                    r_mtx  <= fin;
                    r_busy <= 1'b0;
                    r_st   <= ST_IDLE;
                end
                default: r_st <= ST_IDLE;
            endcase
        end
    end

    assign o_busy = r_busy;
    assign o_mtx  = r_mtx;

endmodule

// ===== src/aapr_pipe.sv =====
// ----------------------------------------------------------------------------
// aapr_pipe: point and normal transform pipeline
// Four stages: offset, products, rounded sums, saturation and output.
// Each stage advances when it is empty or the next one advances.
// ----------------------------------------------------------------------------
module aapr_pipe import aapr_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_hold,
    input  t_mtx             i_mtx,
    input  logic [2:0][31:0] i_pivot,
    aapr_in_if.sink          i_pnt,
    aapr_out_if.source       o_rot
);

    logic [3:0]         r_vld;
    logic [3:0]         adv;
    logic               take;

    logic signed [32:0] r_a_d [3];
    logic [31:0]        r_a_n [3];
    logic [63:0]        r_b_pp [9];
    logic [63:0]        r_b_pn [9];
    logic               r_b_pneg [9];
    logic               r_b_nneg [9];
    logic signed [35:0] r_c_sp [3];
    logic signed [35:0] r_c_sn [3];
    logic [31:0]        r_d_o [6];

    logic [31:0]        pin [3];
    logic [31:0]        nin [3];
    logic signed [32:0] dv [3];
    logic [32:0]        dm [3];
    logic [31:0]        nm [3];
    logic [31:0]        tm [9];
    logic signed [35:0] sp [3];
    logic signed [35:0] sn [3];

    always_comb begin
        adv[3] = !r_vld[3] || o_rot.ready;
        adv[2] = !r_vld[2] || adv[3];
        adv[1] = !r_vld[1] || adv[2];
        adv[0] = !r_vld[0] || adv[1];
        take   = i_pnt.valid && i_pnt.ready;
    end

    assign i_pnt.ready = adv[0] && !i_hold;

    always_comb begin
        pin[0] = i_pnt.point_x;
        pin[1] = i_pnt.point_y;
        pin[2] = i_pnt.point_z;
        nin[0] = i_pnt.normal_x;
        nin[1] = i_pnt.normal_y;
        nin[2] = i_pnt.normal_z;
        for (int i = 0; i < 3; i++) begin
            dv[i] = $signed({pin[i][31], pin[i]}) - $signed({i_pivot[i][31], i_pivot[i]});
            dm[i] = r_a_d[i][32] ? 33'(-r_a_d[i]) : 33'(r_a_d[i]);
            nm[i] = mag32(r_a_n[i]);
        end
        for (int e = 0; e < 9; e++) begin
            tm[e] = mag32(i_mtx[e]);
        end
        for (int i = 0; i < 3; i++) begin
            sp[i] = 36'($signed(i_pivot[i]));
            sn[i] = '0;
            for (int j = 0; j < 3; j++) begin
                sp[i] = sp[i] + 36'(rnd_q30(r_b_pp[3*i+j], r_b_pneg[3*i+j]));
                sn[i] = sn[i] + 36'(rnd_q30(r_b_pn[3*i+j], r_b_nneg[3*i+j]));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (adv[0]) r_vld[0] <= take;
            if (adv[1]) r_vld[1] <= r_vld[0];
            if (adv[2]) r_vld[2] <= r_vld[1];
            if (adv[3]) r_vld[3] <= r_vld[2];
        end
    end

    always_ff @(posedge i_clk) begin
        // offset from the pivot
        if (adv[0] && take) begin
            for (int i = 0; i < 3; i++) begin
                r_a_d[i] <= dv[i];
                r_a_n[i] <= nin[i];
            end
        end
        // magnitude products, sign carried alongside
        if (adv[1] && r_vld[0]) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_b_pp[3*i+j]   <= 64'(tm[3*i+j]) * 64'(dm[j]);
                    r_b_pn[3*i+j]   <= 64'(tm[3*i+j]) * 64'(nm[j]);
                    r_b_pneg[3*i+j] <= i_mtx[3*i+j][31] ^ r_a_d[j][32];
                    r_b_nneg[3*i+j] <= i_mtx[3*i+j][31] ^ r_a_n[j][31];
                end
            end
        end
        // round each term, sum the rows and add the pivot back to the point
        if (adv[2] && r_vld[1]) begin
            for (int i = 0; i < 3; i++) begin
                r_c_sp[i] <= sp[i];
                r_c_sn[i] <= sn[i];
            end
        end
        // saturate into the output register
        if (adv[3] && r_vld[2]) begin
            for (int i = 0; i < 3; i++) begin
                r_d_o[i]     <= sat32(r_c_sp[i]);
                r_d_o[3 + i] <= sat32(r_c_sn[i]);
            end
        end
    end

    assign o_rot.valid            = r_vld[3];
    assign o_rot.rotated_x        = r_d_o[0];
    assign o_rot.rotated_y        = r_d_o[1];
    assign o_rot.rotated_z        = r_d_o[2];
    assign o_rot.rotated_normal_x = r_d_o[3];
    assign o_rot.rotated_normal_y = r_d_o[4];
    assign o_rot.rotated_normal_z = r_d_o[5];

endmodule

// ===== src/aapr_chk.sv =====
// ----------------------------------------------------------------------------
// aapr_chk: port checker of the axis-angle point rotator
// Watches the top-level ports over time; bound to the top level below.
// ----------------------------------------------------------------------------
module aapr_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_cfg_we,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_out_x
);

    // reset empties the pipeline and starts a matrix build
    a_reset_state: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> (!i_out_valid && !i_in_ready))
        else $error("pipeline not empty or port ready after reset");

    // a register write takes the request port out of service
    a_cfg_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> !i_in_ready)
        else $error("request port ready right after a register write");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> $stable(i_out_x))
        else $error("result changed while stalled");

endmodule

bind axis_angle_point_rotator aapr_chk u_aapr_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_cfg_we    (i_cfg_we),
    .i_in_ready  (i_pnt.ready),
    .i_out_valid (o_rot.valid),
    .i_out_ready (o_rot.ready),
    .i_out_x     (o_rot.rotated_x)
);
